// ----- rtl/awb_pkg.sv -----
// Shared constants for the affine warp bilinear sampler.
package awb_pkg;

  localparam int PIX_W = 8;
  localparam int RGB_W = 3 * PIX_W;
  localparam int CFG_AW = 5;
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [2:0] {
    REG_COEF_XX   = 3'd0,
    REG_COEF_XY   = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_COEF_YX   = 3'd3,
    REG_COEF_YY   = 3'd4,
    REG_OFFSET_Y  = 3'd5,
    REG_SRC_WIDTH = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } reg_idx_t;

endpackage

// ----- rtl/awb_fifo.sv -----
// Small register queue used between pipeline sections.
module awb_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 din,
  input  logic                         pop,
  output logic [W-1:0]                 dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  q_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign dout  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= PW'(32'(wp_r) + 1 == DEPTH ? 0 : 32'(wp_r) + 1);
      if (pop)  rp_r <= PW'(32'(rp_r) + 1 == DEPTH ? 0 : 32'(rp_r) + 1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end
endmodule

// ----- rtl/awb_front.sv -----
// Front end: accepts beats, maps requests to source coordinates, classifies them.
module awb_front #(
  parameter int MAX_SRC_DIM = 256,
  parameter int OUT_DIM = 112,
  parameter int FRAC_BITS = 16,
  parameter int OCW = 7,
  parameter int AW = 8,
  parameter int EW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          mode,
  input  logic [awb_pkg::PIX_W-1:0]     pix_col,
  input  logic [awb_pkg::PIX_W-1:0]     pix_row,
  input  logic [awb_pkg::RGB_W-1:0]     rgb,
  input  logic [OCW-1:0]                out_col,
  input  logic [OCW-1:0]                out_row,
  input  logic signed [31:0]            coef_xx,
  input  logic signed [31:0]            coef_xy,
  input  logic signed [31:0]            offset_x,
  input  logic signed [31:0]            coef_yx,
  input  logic signed [31:0]            coef_yy,
  input  logic signed [31:0]            offset_y,
  input  logic [8:0]                    src_width,
  input  logic [8:0]                    src_height,
  input  logic [$clog2(awb_pkg::MID_DEPTH+1)-1:0] mid_cnt,
  output logic                          mid_push,
  output logic [EW-1:0]                 mid_data
);
  localparam int F  = FRAC_BITS;
  localparam int PW = 33 + OCW;
  localparam int SW = PW + 2;
  localparam int DW = ($clog2(MAX_SRC_DIM+1) > 9) ? $clog2(MAX_SRC_DIM+1) : 9;

  logic                      f1_v_r, f1_req_r;
  logic [awb_pkg::PIX_W-1:0] f1_pc_r, f1_pr_r;
  logic [awb_pkg::RGB_W-1:0] f1_rgb_r;
  logic signed [PW-1:0]      px1_r, px2_r, py1_r, py2_r;
  logic signed [PW-1:0]      px1_nxt, px2_nxt, py1_nxt, py2_nxt;
  logic                      acc, keep;
  logic signed [SW-1:0]      sx, sy, limx, limy;
  logic [DW-1:0]             wz, hz, w, h;
  logic signed [DW:0]        wm1, hm1;
  logic                      outside;
  logic [AW-1:0]             ya, xa;
  logic [F-1:0]              fx, fy;

  assign full = (32'(mid_cnt) + 32'(f1_v_r)) >= awb_pkg::MID_DEPTH;
  assign acc  = push && !full;
  assign keep = mode ? (32'(out_col) < OUT_DIM && 32'(out_row) < OUT_DIM)
                     : (32'(pix_col) < MAX_SRC_DIM && 32'(pix_row) < MAX_SRC_DIM);

  always_comb begin
    px1_nxt = coef_xx * $signed({1'b0, out_col});
    px2_nxt = coef_xy * $signed({1'b0, out_row});
    py1_nxt = coef_yx * $signed({1'b0, out_col});
    py2_nxt = coef_yy * $signed({1'b0, out_row});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_req_r <= mode;
      f1_pc_r  <= pix_col;
      f1_pr_r  <= pix_row;
      f1_rgb_r <= rgb;
      px1_r    <= px1_nxt;
      px2_r    <= px2_nxt;
      py1_r    <= py1_nxt;
      py2_r    <= py2_nxt;
    end
  end

  // dimensions saturate at the store size; zero gives a negative limit
  always_comb begin
    wz   = DW'(src_width);
    hz   = DW'(src_height);
    w    = (32'(wz) > MAX_SRC_DIM) ? DW'(MAX_SRC_DIM) : wz;
    h    = (32'(hz) > MAX_SRC_DIM) ? DW'(MAX_SRC_DIM) : hz;
    wm1  = $signed({1'b0, w}) - (DW+1)'(1);
    hm1  = $signed({1'b0, h}) - (DW+1)'(1);
    limx = SW'(wm1) <<< F;
    limy = SW'(hm1) <<< F;
    sx   = SW'(px1_r) + SW'(px2_r) + SW'(offset_x);
    sy   = SW'(py1_r) + SW'(py2_r) + SW'(offset_y);
    outside = (sx < 0) || (sy < 0) || (sx >= limx) || (sy >= limy);
    if (f1_req_r) begin
      xa = sx[F+AW-1:F];
      ya = sy[F+AW-1:F];
      fx = sx[F-1:0];
      fy = sy[F-1:0];
    end else begin
      xa = AW'(f1_pc_r);
      ya = AW'(f1_pr_r);
      fx = '0;
      fy = '0;
    end
  end

  assign mid_push = f1_v_r;
  assign mid_data = {f1_req_r, outside, ya, xa, fx, fy, f1_rgb_r};
endmodule

// ----- rtl/awb_back.sv -----
// Back end: banked frame store, pixel writes and bilinear blend pipeline.
module awb_back #(
  parameter int FRAC_BITS = 16,
  parameter int AW = 8,
  parameter int EW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mid_empty,
  input  logic [EW-1:0]                 mid_data,
  output logic                          mid_pop,
  input  logic [$clog2(awb_pkg::OUT_DEPTH+1)-1:0] out_cnt,
  output logic                          out_push,
  output logic [awb_pkg::RGB_W:0]       out_data
);
  localparam int F  = FRAC_BITS;
  localparam int BA = 2 * (AW - 1);
  localparam int BD = 1 << BA;
  localparam int TW = awb_pkg::PIX_W + F + 1;
  localparam int VW = 2 * F + 10;

  logic              h_req, h_out;
  logic [AW-1:0]     h_ya, h_xa;
  logic [F-1:0]      h_fx, h_fy;
  logic [awb_pkg::RGB_W-1:0] h_rgb;

  logic [awb_pkg::RGB_W-1:0] rd_r [4];
  logic              b1_v_r, b1_out_r, b1_xp_r, b1_yp_r;
  logic [F-1:0]      b1_fx_r, b1_fy_r;
  logic              b2_v_r, b2_out_r;
  logic [F:0]        b2_gy_r;
  logic [F-1:0]      b2_fy_r;
  logic [TW-1:0]     b2_top_r [3];
  logic [TW-1:0]     b2_bot_r [3];
  logic              b3_v_r, b3_out_r;
  logic [VW-1:0]     b3_pt_r [3];
  logic [VW-1:0]     b3_pb_r [3];
  logic [TW-1:0]     top_nxt [3];
  logic [TW-1:0]     bot_nxt [3];
  logic [awb_pkg::RGB_W-1:0] p00, p01, p10, p11;
  logic [F:0]        gx;
  logic [awb_pkg::PIX_W-1:0] res [3];
  logic [VW-1:0]     v;

  assign {h_req, h_out, h_ya, h_xa, h_fx, h_fy, h_rgb} = mid_data;

  // room in the result queue for everything already in the pipe
  assign mid_pop = !mid_empty &&
                   (32'(out_cnt) + 32'(b1_v_r) + 32'(b2_v_r) + 32'(b3_v_r)
                    < awb_pkg::OUT_DEPTH);

  // bank = {row parity, col parity}: the four neighbors hit distinct banks
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [awb_pkg::RGB_W-1:0] mem [BD];
    logic [AW-1:0] rrow, rcol;
    logic [BA-1:0] ra, wa;
    logic          we;
    always_comb begin
      rrow = (h_ya[0] == b[1]) ? h_ya : h_ya + AW'(1);
      rcol = (h_xa[0] == b[0]) ? h_xa : h_xa + AW'(1);
      ra   = {rrow[AW-1:1], rcol[AW-1:1]};
      wa   = {h_ya[AW-1:1], h_xa[AW-1:1]};
      we   = mid_pop && !h_req && (h_ya[0] == b[1]) && (h_xa[0] == b[0]);
    end
    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= h_rgb;
      end
      rd_r[b] <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= mid_pop && h_req;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  always_comb begin
    p00 = rd_r[{b1_yp_r, b1_xp_r}];
    p01 = rd_r[{b1_yp_r, !b1_xp_r}];
    p10 = rd_r[{!b1_yp_r, b1_xp_r}];
    p11 = rd_r[{!b1_yp_r, !b1_xp_r}];
    gx  = (F+1)'(1) << F;
    gx  = gx - (F+1)'(b1_fx_r);
    for (int ch = 0; ch < 3; ch++) begin
      top_nxt[ch] = TW'(p00[(2-ch)*8 +: 8]) * TW'(gx) + TW'(p01[(2-ch)*8 +: 8]) * TW'(b1_fx_r);
      bot_nxt[ch] = TW'(p10[(2-ch)*8 +: 8]) * TW'(gx) + TW'(p11[(2-ch)*8 +: 8]) * TW'(b1_fx_r);
    end
  end

  always_ff @(posedge clk) begin
    b1_out_r <= h_out;
    b1_xp_r  <= h_xa[0];
    b1_yp_r  <= h_ya[0];
    b1_fx_r  <= h_fx;
    b1_fy_r  <= h_fy;
    b2_out_r <= b1_out_r;
    b2_gy_r  <= ((F+1)'(1) << F) - (F+1)'(b1_fy_r);
    b2_fy_r  <= b1_fy_r;
    b3_out_r <= b2_out_r;
    for (int ch = 0; ch < 3; ch++) begin
      b2_top_r[ch] <= top_nxt[ch];
      b2_bot_r[ch] <= bot_nxt[ch];
      b3_pt_r[ch]  <= VW'(b2_top_r[ch]) * VW'(b2_gy_r);
      b3_pb_r[ch]  <= VW'(b2_bot_r[ch]) * VW'(b2_fy_r);
    end
  end

  // round half up, drop the fraction, clamp; outside requests give zero
  always_comb begin
    v = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = b3_pt_r[ch] + b3_pb_r[ch] + (VW'(1) << (2*F - 1));
      if (v[VW-1:2*F] > 10'd255) begin
        res[ch] = 8'hFF;
      end else begin
        res[ch] = v[2*F +: 8];
      end
      if (b3_out_r) begin
        res[ch] = '0;
      end
    end
  end

  assign out_push = b3_v_r;
  assign out_data = {b3_out_r, res[0], res[1], res[2]};
endmodule

// ----- rtl/affine_warp_bilinear_sampler.sv -----
// Path: a request passes the front register, mid queue, stages b1-b3 and the result queue.
// Throughput: one beat per cycle each side unless a queue is full; writes give no result.
// Four parity banks of the frame store serve all neighbors of a pixel in the same cycle.
// Reset: control and queues clear, registers take their defaults; the frame store
// is not cleared and holds nothing defined until written.
module affine_warp_bilinear_sampler #(
  parameter int MAX_SRC_DIM = 256,
  parameter int OUT_DIM = 112,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [7:0]  in_pix_col,
  input  logic [7:0]  in_pix_row,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [((OUT_DIM > 1) ? $clog2(OUT_DIM) : 1)-1:0] in_out_col,
  input  logic [((OUT_DIM > 1) ? $clog2(OUT_DIM) : 1)-1:0] in_out_row,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_outside,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [awb_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int OCW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int AW  = ($clog2(MAX_SRC_DIM) < 2) ? 2 : $clog2(MAX_SRC_DIM);
  localparam int EW  = 2 + 2 * AW + 2 * FRAC_BITS + awb_pkg::RGB_W;
  localparam int MCW = $clog2(awb_pkg::MID_DEPTH+1);
  localparam int OQW = $clog2(awb_pkg::OUT_DEPTH+1);

  logic signed [31:0] coef_xx_r, coef_xy_r, offset_x_r, coef_yx_r, coef_yy_r, offset_y_r;
  logic [8:0]         src_width_r, src_height_r;
  logic               cfg_we;
  awb_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = awb_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r    <= 32'sd1 <<< FRAC_BITS;
      coef_xy_r    <= '0;
      offset_x_r   <= '0;
      coef_yx_r    <= '0;
      coef_yy_r    <= 32'sd1 <<< FRAC_BITS;
      offset_y_r   <= '0;
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        awb_pkg::REG_COEF_XX:    coef_xx_r    <= pwdata;
        awb_pkg::REG_COEF_XY:    coef_xy_r    <= pwdata;
        awb_pkg::REG_OFFSET_X:   offset_x_r   <= pwdata;
        awb_pkg::REG_COEF_YX:    coef_yx_r    <= pwdata;
        awb_pkg::REG_COEF_YY:    coef_yy_r    <= pwdata;
        awb_pkg::REG_OFFSET_Y:   offset_y_r   <= pwdata;
        awb_pkg::REG_SRC_WIDTH:  src_width_r  <= pwdata[8:0];
        awb_pkg::REG_SRC_HEIGHT: src_height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      awb_pkg::REG_COEF_XX:    prdata = coef_xx_r;
      awb_pkg::REG_COEF_XY:    prdata = coef_xy_r;
      awb_pkg::REG_OFFSET_X:   prdata = offset_x_r;
      awb_pkg::REG_COEF_YX:    prdata = coef_yx_r;
      awb_pkg::REG_COEF_YY:    prdata = coef_yy_r;
      awb_pkg::REG_OFFSET_Y:   prdata = offset_y_r;
      awb_pkg::REG_SRC_WIDTH:  prdata = {23'd0, src_width_r};
      awb_pkg::REG_SRC_HEIGHT: prdata = {23'd0, src_height_r};
      default:                 prdata = '0;
    endcase
  end

  logic              mid_push, mid_pop, mid_empty;
  logic [EW-1:0]     mid_din, mid_dout;
  logic [MCW-1:0]    mid_cnt;
  logic              oq_push;
  logic [awb_pkg::RGB_W:0] oq_din, oq_dout;
  logic [OQW-1:0]    oq_cnt;

  awb_front #(
    .MAX_SRC_DIM(MAX_SRC_DIM), .OUT_DIM(OUT_DIM), .FRAC_BITS(FRAC_BITS),
    .OCW(OCW), .AW(AW), .EW(EW)
  ) u_front (
    .clk, .rst_n, .push, .full,
    .mode(in_mode), .pix_col(in_pix_col), .pix_row(in_pix_row),
    .rgb({in_red_in, in_green_in, in_blue_in}),
    .out_col(in_out_col), .out_row(in_out_row),
    .coef_xx(coef_xx_r), .coef_xy(coef_xy_r), .offset_x(offset_x_r),
    .coef_yx(coef_yx_r), .coef_yy(coef_yy_r), .offset_y(offset_y_r),
    .src_width(src_width_r), .src_height(src_height_r),
    .mid_cnt, .mid_push, .mid_data(mid_din)
  );

  awb_fifo #(.W(EW), .DEPTH(awb_pkg::MID_DEPTH)) u_mid_q (
    .clk, .rst_n, .push(mid_push), .din(mid_din), .pop(mid_pop),
    .dout(mid_dout), .empty(mid_empty), .count(mid_cnt)
  );

  awb_back #(.FRAC_BITS(FRAC_BITS), .AW(AW), .EW(EW)) u_back (
    .clk, .rst_n, .mid_empty, .mid_data(mid_dout), .mid_pop,
    .out_cnt(oq_cnt), .out_push(oq_push), .out_data(oq_din)
  );

  awb_fifo #(.W(awb_pkg::RGB_W + 1), .DEPTH(awb_pkg::OUT_DEPTH)) u_out_q (
    .clk, .rst_n, .push(oq_push), .din(oq_din), .pop(pop && !empty),
    .dout(oq_dout), .empty(empty), .count(oq_cnt)
  );

  assign {out_outside, out_red_out, out_green_out, out_blue_out} = oq_dout;
endmodule
